// ----- hw/rtl/rrts_pkg.sv -----
// shared types, constants and helpers for the round-robin tick scheduler
// no dependencies; used by rrts_cell, rrts_chain and round_robin_tick_scheduler
package rrts_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 2'd1;

   // reset values and limits
   localparam logic [7:0]  QUANTUM_RESET = 8'd1;
   localparam logic [15:0] LIMIT_RESET   = 16'd100;
   localparam logic [15:0] TIME_MAX      = 16'hFFFF;
   localparam logic [7:0]  DONE_MAX      = 8'hFF;

   // request beat: job arrival or one tick
   typedef struct packed {
      logic       func;
      logic [7:0] job_id;
      logic [7:0] service_need;
   } req_type;

   // result beat, one per tick
   typedef struct packed {
      logic        busy_res;
      logic [7:0]  running_id;
      logic        finished;
      logic [15:0] start_time;
      logic [15:0] end_time;
      logic        all_done;
      logic        overflow;
      logic [15:0] tick_time;
   } rsp_type;

   // payload of one table entry
   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  need;
      logic [7:0]  done;
      logic [15:0] start;
   } entry_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic        append_en;
      logic        drop_en;
      logic        serve_en;
      logic [7:0]  id;
      logic [7:0]  need;
      logic [15:0] now;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PURGE,
      ST_RUN,
      ST_EMIT
   } state_type;

   // saturating service counter step
   function automatic logic [7:0] done_sat_inc(input logic [7:0] done);
      done_sat_inc = (done == DONE_MAX) ? done : done + 8'd1;
   endfunction

endpackage

// ----- hw/rtl/rrts_cell.sv -----
// one ready-table entry of the scheduler chain
// depends on rrts_pkg; instantiated by rrts_chain
module rrts_cell #(
   parameter int IDX_W    = 4,
   parameter int CELL_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rrts_pkg::cell_cmd_type cmd,
   input  logic [IDX_W-1:0]      append_pos,
   input  logic [IDX_W-1:0]      sel_pos,
   input  rrts_pkg::entry_type   nb_entry,
   input  logic                  nb_started,
   output rrts_pkg::entry_type   entry,
   output logic                  started
);

   localparam logic [IDX_W-1:0] MY_POS = IDX_W'(CELL_IDX);

   rrts_pkg::entry_type entry_ff, entry_in;
   logic                started_ff, started_in;
   logic                do_shift, do_append, do_serve;

   assign do_shift  = cmd.drop_en && (MY_POS >= sel_pos);
   assign do_append = cmd.append_en && (MY_POS == append_pos);
   assign do_serve  = cmd.serve_en && (MY_POS == sel_pos);

   // shift from the right neighbor, load a new job, or charge one tick
   always_comb begin
      entry_in   = entry_ff;
      started_in = started_ff;
      if (do_shift) begin
         entry_in   = nb_entry;
         started_in = nb_started;
      end else if (do_append) begin
         entry_in.id    = cmd.id;
         entry_in.need  = cmd.need;
         entry_in.done  = 8'd0;
         entry_in.start = 16'd0;
         started_in     = 1'b0;
      end else if (do_serve) begin
         entry_in.done = rrts_pkg::done_sat_inc(entry_ff.done);
         if (!started_ff) begin
            entry_in.start = cmd.now;
            started_in     = 1'b1;
         end
      end
   end

   // started flag
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry   = entry_ff;
   assign started = started_ff;

endmodule

// ----- hw/rtl/rrts_chain.sv -----
// ready table as a row of cells kept in arrival order, with cursor selection
// depends on rrts_pkg and rrts_cell; instantiated by round_robin_tick_scheduler
module rrts_chain #(
   parameter int TABLE_DEPTH = 16,
   parameter int IDX_W       = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rrts_pkg::cell_cmd_type cmd,
   input  logic [IDX_W-1:0]       append_pos,
   input  logic [IDX_W-1:0]       sel_pos,
   output rrts_pkg::entry_type    sel_entry,
   output logic                   sel_started
);

   rrts_pkg::entry_type cell_entry   [TABLE_DEPTH];
   logic                cell_started [TABLE_DEPTH];

   // each cell takes its right neighbor on a drop; the last one takes an empty entry
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      rrts_pkg::entry_type nb_entry;
      logic                nb_started;

      if (g == TABLE_DEPTH - 1) begin : g_last
         assign nb_entry   = '0;
         assign nb_started = 1'b0;
      end else begin : g_mid
         assign nb_entry   = cell_entry[g+1];
         assign nb_started = cell_started[g+1];
      end

      rrts_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .append_pos (append_pos),
         .sel_pos    (sel_pos),
         .nb_entry   (nb_entry),
         .nb_started (nb_started),
         .entry      (cell_entry[g]),
         .started    (cell_started[g])
      );
   end

   // entry under the cursor
   assign sel_entry   = cell_entry[sel_pos];
   assign sel_started = cell_started[sel_pos];

endmodule

// ----- hw/rtl/round_robin_tick_scheduler.sv -----
// Arrival beat: no result; the next beat may follow at once.
// Tick beat: purge state (repeats, one unstarted job dropped each time, past the admission limit),
// run, emit, then the registered result; a purge that empties the table goes straight to emit, and
// a tick after the schedule has ended goes straight from idle to emit. One tick in flight at a
// time; the next beat can be taken in the cycle the result appears (later while a held result
// stalls); synchronous reset clears control state and sets quantum 1, limit 100.
// depends on rrts_pkg and rrts_chain
module round_robin_tick_scheduler #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rrts_pkg::req_type                 req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rrts_pkg::rsp_type                 rsp_data,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rrts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rrts_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   rrts_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    cursor_ff, cursor_in;
   logic                cursor_valid_ff, cursor_valid_in;
   logic [7:0]          slice_ff, slice_in;
   logic [15:0]         now_ff, now_in;
   logic                overflow_ff, overflow_in;
   logic [7:0]          quantum_ff, quantum_in;
   logic [15:0]         limit_ff, limit_in;
   rrts_pkg::rsp_type   res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rrts_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   rrts_pkg::cell_cmd_type cmd;
   rrts_pkg::entry_type    sel_entry;
   logic                   sel_started;

   logic             req_fire, csr_fire, out_free;
   logic             limit_hit, sched_over, purge_hit;
   logic [7:0]       quantum_eff, done_inc;
   logic [CNT_W-1:0] count_dec, cursor_wide, cursor_next;
   logic             finish;
   logic [15:0]      now_inc;

   // handshakes
   assign req_stall = (state_ff != rrts_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // shared conditions
   assign limit_hit   = (now_ff >= limit_ff);
   assign sched_over  = limit_hit && (count_ff == '0);
   assign purge_hit   = cursor_valid_ff && limit_hit && !sel_started;
   assign quantum_eff = (quantum_ff == 8'd0) ? 8'd1 : quantum_ff;
   assign count_dec   = count_ff - CNT_W'(1);
   assign cursor_wide = CNT_W'(cursor_ff);
   assign cursor_next = cursor_wide + CNT_W'(1);
   assign done_inc    = rrts_pkg::done_sat_inc(sel_entry.done);
   assign finish      = cursor_valid_ff && (done_inc >= sel_entry.need);
   assign now_inc     = (now_ff == rrts_pkg::TIME_MAX) ? now_ff : now_ff + 16'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (req_fire && req_data.func) begin
               state_in = sched_over ? rrts_pkg::ST_EMIT : rrts_pkg::ST_PURGE;
            end
         end
         rrts_pkg::ST_PURGE: begin
            if (purge_hit && (count_dec == '0)) begin
               state_in = rrts_pkg::ST_EMIT;
            end else if (!purge_hit) begin
               state_in = rrts_pkg::ST_RUN;
            end
         end
         rrts_pkg::ST_RUN: begin
            state_in = rrts_pkg::ST_EMIT;
         end
         rrts_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = rrts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrts_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and cell commands
   always_comb begin
      count_in        = count_ff;
      cursor_in       = cursor_ff;
      cursor_valid_in = cursor_valid_ff;
      slice_in        = slice_ff;
      now_in          = now_ff;
      overflow_in     = overflow_ff;
      quantum_in      = quantum_ff;
      limit_in        = limit_ff;
      res_in          = res_ff;
      cmd             = '0;
      cmd.id          = req_data.job_id;
      cmd.need        = req_data.service_need;
      cmd.now         = now_ff;

      // register writes
      if (csr_fire) begin
         unique case (csr_index)
            rrts_pkg::CSR_QUANTUM: quantum_in = csr_data[7:0];
            rrts_pkg::CSR_LIMIT:   limit_in   = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (req_fire && !req_data.func) begin
               // arrival before the limit: append at the tail, or flag overflow when full
               if (!limit_hit) begin
                  if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                     cmd.append_en = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
            end else if (req_fire) begin
               if (sched_over) begin
                  res_in           = '0;
                  res_in.all_done  = 1'b1;
                  res_in.overflow  = overflow_ff;
                  res_in.tick_time = now_ff;
               end else if (!cursor_valid_ff) begin
                  // place the cursor at the head
                  slice_in = 8'd0;
                  if (count_ff != '0) begin
                     cursor_in       = '0;
                     cursor_valid_in = 1'b1;
                  end
               end else if (slice_ff >= quantum_eff) begin
                  // quantum spent: move one position, wrap to the head
                  slice_in  = 8'd0;
                  cursor_in = (cursor_next >= count_ff) ? '0 : IDX_W'(cursor_next);
               end
            end
         end
         rrts_pkg::ST_PURGE: begin
            // remove one never-started job per cycle once past the limit
            if (purge_hit) begin
               cmd.drop_en = 1'b1;
               count_in    = count_dec;
               slice_in    = 8'd0;
               if (count_dec == '0) begin
                  cursor_valid_in  = 1'b0;
                  res_in           = '0;
                  res_in.all_done  = 1'b1;
                  res_in.overflow  = overflow_ff;
                  res_in.tick_time = now_ff;
               end else if (cursor_wide >= count_dec) begin
                  cursor_in       = '0;
                  cursor_valid_in = 1'b1;
               end
            end
         end
         rrts_pkg::ST_RUN: begin
            // charge one tick to the selected job
            res_in           = '0;
            res_in.overflow  = overflow_ff;
            res_in.tick_time = now_ff;
            if (cursor_valid_ff) begin
               cmd.serve_en      = 1'b1;
               res_in.busy_res   = 1'b1;
               res_in.running_id = sel_entry.id;
               slice_in          = slice_ff + 8'd1;
               if (finish) begin
                  cmd.drop_en       = 1'b1;
                  count_in          = count_dec;
                  slice_in          = 8'd0;
                  res_in.finished   = 1'b1;
                  res_in.start_time = sel_started ? sel_entry.start : now_ff;
                  res_in.end_time   = now_ff;
                  if (cursor_wide >= count_dec) begin
                     cursor_valid_in = 1'b0;
                  end
               end
            end
            now_in          = now_inc;
            res_in.all_done = (now_inc >= limit_ff) && (count_in == '0);
         end
         rrts_pkg::ST_EMIT: ;
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == rrts_pkg::ST_EMIT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= rrts_pkg::ST_IDLE;
         count_ff        <= '0;
         cursor_ff       <= '0;
         cursor_valid_ff <= 1'b0;
         slice_ff        <= 8'd0;
         now_ff          <= 16'd0;
         overflow_ff     <= 1'b0;
         quantum_ff      <= rrts_pkg::QUANTUM_RESET;
         limit_ff        <= rrts_pkg::LIMIT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         cursor_ff       <= cursor_in;
         cursor_valid_ff <= cursor_valid_in;
         slice_ff        <= slice_in;
         now_ff          <= now_in;
         overflow_ff     <= overflow_in;
         quantum_ff      <= quantum_in;
         limit_ff        <= limit_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ready table
   rrts_chain #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .append_pos  (IDX_W'(count_ff)),
      .sel_pos     (cursor_ff),
      .sel_entry   (sel_entry),
      .sel_started (sel_started)
   );

   // cursor always points inside the occupied part of the table
   a_cursor_in_table: assert property (@(posedge clock) disable iff (reset)
      cursor_valid_ff |-> (cursor_wide < count_ff))
      else $error("cursor outside occupied table");

   // occupancy never exceeds the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("table count beyond depth");

   // a new result appears only out of the emit state
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == rrts_pkg::ST_EMIT))
      else $error("result raised outside emit");

   // time never runs backward
   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (now_ff >= $past(now_ff)))
      else $error("time counter went backward");

   // the table shrinks or grows by at most one job per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> ((count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1))
                  || (count_ff == $past(count_ff) - CNT_W'(1))))
      else $error("table count jumped");

endmodule

// ----- dv/round_robin_tick_scheduler_checker.sv -----
// scoreboard for the round-robin tick scheduler: tracks csr writes, predicts each tick report
// and compares it against the result channel
// depends on rrts_pkg
module round_robin_tick_scheduler_checker
   import rrts_pkg::*;
#(
   parameter int   DEPTH     = 16,
   parameter logic FUNC_TICK = 1'b1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending,
   output logic [15:0]            sched_time
);

   // shadow configuration
   logic [7:0]  quantum_reg;
   logic [15:0] limit_reg;

   // shadow ready table, oldest job first
   logic [7:0]  job_id_tab      [DEPTH];
   logic [7:0]  job_need_tab    [DEPTH];
   logic [7:0]  job_served_tab  [DEPTH];
   logic [15:0] job_start_tab   [DEPTH];
   logic        job_started_tab [DEPTH];
   int          job_count;
   int          cursor_pos;
   logic        cursor_live;
   int          slice_ticks;
   logic [15:0] clock_now;
   logic        overflow_hit;

   rsp_type     tick_reports[$];
   int          mismatch_n = 0;
   int          pending_n  = 0;

   assign fail_count = mismatch_n;
   assign pending    = pending_n;

   task automatic clear_schedule();
      quantum_reg  = QUANTUM_RESET;
      limit_reg    = LIMIT_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         job_id_tab[i]      = '0;
         job_need_tab[i]    = '0;
         job_served_tab[i]  = '0;
         job_start_tab[i]   = '0;
         job_started_tab[i] = 1'b0;
      end
      job_count    = 0;
      cursor_pos   = 0;
      cursor_live  = 1'b0;
      slice_ticks  = 0;
      clock_now    = '0;
      overflow_hit = 1'b0;
   endtask

   // remove one job and close the gap behind it
   task automatic drop_job(input int pos);
      if (pos >= job_count)
         return;
      for (int i = pos; i + 1 < job_count; i++) begin
         job_id_tab[i]      = job_id_tab[i+1];
         job_need_tab[i]    = job_need_tab[i+1];
         job_served_tab[i]  = job_served_tab[i+1];
         job_start_tab[i]   = job_start_tab[i+1];
         job_started_tab[i] = job_started_tab[i+1];
      end
      job_count--;
      job_started_tab[job_count] = 1'b0;
      slice_ticks = 0;
      if (cursor_pos >= job_count)
         cursor_live = 1'b0;
   endtask

   // apply one request beat; a tick queues the report it should produce
   task automatic schedule_beat(input req_type beat);
      rsp_type report;
      int      quantum;
      int      c;
      logic    running;
      quantum = (quantum_reg == 8'd0) ? 1 : int'(quantum_reg);
      // arrival: append unless late or table full
      if (beat.func != FUNC_TICK) begin
         if (clock_now < limit_reg) begin
            if (job_count < DEPTH) begin
               job_id_tab[job_count]      = beat.job_id;
               job_need_tab[job_count]    = beat.service_need;
               job_served_tab[job_count]  = '0;
               job_start_tab[job_count]   = '0;
               job_started_tab[job_count] = 1'b0;
               job_count++;
            end else begin
               overflow_hit = 1'b1;
            end
         end
         return;
      end
      report           = '0;
      report.tick_time = clock_now;
      running          = !(clock_now >= limit_reg && job_count == 0);
      if (running) begin
         // cursor advance once the slice is used up
         if (!cursor_live) begin
            slice_ticks = 0;
            if (job_count > 0) begin
               cursor_pos  = 0;
               cursor_live = 1'b1;
            end
         end else if (slice_ticks >= quantum) begin
            slice_ticks = 0;
            cursor_pos++;
            if (cursor_pos >= job_count)
               cursor_pos = 0;
         end
         // past the limit, jobs that never ran are thrown out
         while (running && cursor_live && clock_now >= limit_reg &&
                cursor_pos < job_count && !job_started_tab[cursor_pos]) begin
            drop_job(cursor_pos);
            if (job_count == 0) begin
               running = 1'b0;
            end else if (!cursor_live) begin
               cursor_pos  = 0;
               cursor_live = 1'b1;
            end
         end
      end
      if (running) begin
         // serve one unit to the job under the cursor
         if (cursor_live && cursor_pos < job_count) begin
            c                 = cursor_pos;
            report.busy_res   = 1'b1;
            report.running_id = job_id_tab[c];
            if (!job_started_tab[c]) begin
               job_started_tab[c] = 1'b1;
               job_start_tab[c]   = clock_now;
            end
            if (job_served_tab[c] != DONE_MAX)
               job_served_tab[c] = job_served_tab[c] + 8'd1;
            slice_ticks++;
            if (job_served_tab[c] >= job_need_tab[c]) begin
               report.finished   = 1'b1;
               report.start_time = job_start_tab[c];
               report.end_time   = clock_now;
               drop_job(c);
            end
         end
         if (clock_now != TIME_MAX)
            clock_now = clock_now + 16'd1;
         report.all_done = (clock_now >= limit_reg && job_count == 0);
      end else begin
         report.all_done = 1'b1;
      end
      report.overflow = overflow_hit;
      tick_reports.push_back(report);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_n++;
      end
   endtask

   // compare one result beat against the oldest predicted report
   task automatic compare_report(input rsp_type got);
      rsp_type want;
      if (tick_reports.size() == 0) begin
         $error("result beat with no tick pending: tick_time %0d", got.tick_time);
         mismatch_n++;
         return;
      end
      want = tick_reports.pop_front();
      check_field("busy_res",   16'(want.busy_res),   16'(got.busy_res));
      check_field("running_id", 16'(want.running_id), 16'(got.running_id));
      check_field("finished",   16'(want.finished),   16'(got.finished));
      check_field("start_time", want.start_time,      got.start_time);
      check_field("end_time",   want.end_time,        got.end_time);
      check_field("all_done",   16'(want.all_done),   16'(got.all_done));
      check_field("overflow",   16'(want.overflow),   16'(got.overflow));
      check_field("tick_time",  want.tick_time,       got.tick_time);
   endtask

   // sample every channel at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         clear_schedule();
         tick_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_QUANTUM: quantum_reg = csr_data[7:0];
               CSR_LIMIT:   limit_reg   = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            schedule_beat(req_data);
         if (rsp_valid && !rsp_stall)
            compare_report(rsp_data);
      end
      pending_n  <= tick_reports.size();
      sched_time <= clock_now;
   end

endmodule

// ----- dv/round_robin_tick_scheduler_tb.sv -----
// testbench top for round_robin_tick_scheduler: clock, reset, job and tick stimulus,
// csr phases and the final verdict
// depends on rrts_pkg, round_robin_tick_scheduler and round_robin_tick_scheduler_checker
module round_robin_tick_scheduler_tb;
   import rrts_pkg::*;

   localparam int   TABLE_DEPTH = 16;
   localparam logic FUNC_ARRIVE = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int   PHASES      = 14;
   localparam int   PHASE_ITEMS = 105;
   localparam int   SETTLE      = 40;
   localparam int   CYCLE_LIMIT = 3000000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   int          fail_count;
   int          pending;
   logic [15:0] sched_time;
   logic        idle_on  = 1'b1;
   int          cycle_n  = 0;

   always #1 clock = ~clock;

   round_robin_tick_scheduler #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   round_robin_tick_scheduler_checker #(
      .DEPTH     (TABLE_DEPTH),
      .FUNC_TICK (FUNC_TICK)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending),
      .sched_time (sched_time)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
      if (cycle_n == CYCLE_LIMIT) begin
         $display("round_robin_tick_scheduler regression: fail");
         $finish;
      end
   end

   // result-side stall bursts, cut short once idling is switched off
   initial begin
      forever begin
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (idle_on) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) begin
               if (idle_on)
                  @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   // one request beat, with an optional gap ahead of it
   task automatic send_beat(input req_type beat);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_arrival(input logic [7:0] id, input logic [7:0] need);
      req_type beat;
      beat.func         = FUNC_ARRIVE;
      beat.job_id       = id;
      beat.service_need = need;
      send_beat(beat);
   endtask

   // tick beats carry random junk in the job fields
   task automatic send_tick();
      req_type beat;
      beat.func         = FUNC_TICK;
      beat.job_id       = 8'($urandom);
      beat.service_need = 8'($urandom);
      send_beat(beat);
   endtask

   // mostly short jobs, now and then zero, long or the maximum
   function automatic logic [7:0] pick_need();
      int r;
      r = $urandom_range(0, 31);
      if (r == 0)
         return 8'd0;
      if (r == 1)
         return 8'd255;
      if (r < 4)
         return 8'($urandom_range(16, 80));
      return 8'($urandom_range(1, 12));
   endfunction

   // wait for every tick report, then let any arrival finish
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write quantum, limit and an unused index back to back
   task automatic program_regs(input logic [7:0] quantum, input logic [15:0] limit);
      csr_valid <= 1'b1;
      csr_index <= CSR_QUANTUM;
      csr_data  <= {8'($urandom), quantum};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_LIMIT;
      csr_data  <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_data  <= 16'($urandom);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0]  quantum;
      logic [15:0] limit;
      int          counted;
      int          burst;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, zero service, then a full table and one drop
      send_arrival(8'h00, 8'd0);
      send_arrival(8'hFF, 8'd255);
      send_arrival(8'hAA, 8'd1);
      send_arrival(8'h55, 8'h80);
      for (int i = 4; i < TABLE_DEPTH + 1; i++)
         send_arrival(8'(i), 8'($urandom_range(1, 4)));
      repeat (8) send_tick();
      drain();

      // random phases over a spread of quantum and limit settings
      for (int p = 0; p < PHASES; p++) begin
         quantum = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : (p == 2) ? 8'd1 :
                   8'($urandom_range(1, 6));
         limit   = (p == 3) ? 16'd0 : sched_time + 16'($urandom_range(10, 80));
         idle_on = (p % 4 != 3);
         program_regs(quantum, limit);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            if (sched_time < limit && $urandom_range(0, 1) == 1) begin
               // arrival burst, sometimes long enough to overrun the table
               burst = (p % 5 == 1 && counted == 0) ? TABLE_DEPTH + 2 : $urandom_range(1, 6);
               repeat (burst) begin
                  if (sched_time < limit)
                     counted++;
                  send_arrival(8'($urandom), pick_need());
               end
            end else begin
               // tick burst, with stray late arrivals once past the limit
               repeat ($urandom_range(1, 10)) begin
                  if (sched_time >= limit && $urandom_range(0, 9) == 0) begin
                     send_arrival(8'($urandom), pick_need());
                  end else begin
                     counted++;
                     send_tick();
                  end
               end
            end
         end
         drain();
      end

      // last part, no idling: a short back-to-back run with the widest limit
      idle_on = 1'b0;
      program_regs(8'd2, TIME_MAX);
      send_arrival(8'h3C, 8'd20);
      send_arrival(8'hC3, 8'd1);
      send_arrival(8'h7E, 8'd0);
      repeat (40) send_tick();
      drain();

      if (fail_count == 0 && pending == 0)
         $display("round_robin_tick_scheduler regression: pass");
      else
         $display("round_robin_tick_scheduler regression: fail");
      $finish;
   end

endmodule
